/* design/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Action and status codes, cell operations and the control bundle that the
// queue controller hands to each row of storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    localparam int DATA_W    = 32;
    localparam int ACTION_W  = 3;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;
    localparam int DEPTH_DEF = 64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_CLEAR      = 3'd4,
        ACT_REVERSE    = 3'd5,
        ACT_QUERY      = 3'd6
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // what every cell of a row does when it is clocked
    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_SHIFT_IN  = 2'd1,
        CELL_SHIFT_OUT = 2'd2,
        CELL_APPEND    = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  push_data;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* design/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit values
// Two rows of cells hold the queue, one in start-to-end order and one in
// end-to-start order, so both physical ends always sit in cell 0 of a row.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_action, s_value
//  m_      | out       | m_valid / m_ready  | m_status, m_front_value, m_back_value,
//          |           |                    | m_count, m_is_empty
//
//  one beat per cycle while the output is not stalled; the result is written to the
//  output register by the same clock edge that makes the single update of the cell rows.
//  s_ready is high while the output register is empty or being drained.
//  synchronous active-low reset empties the queue and clears the reversal flag;
//  cell contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [deq_pkg::ACTION_W-1:0]          s_action,
    input  wire logic signed [deq_pkg::DATA_W-1:0]     s_value,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [deq_pkg::STATUS_W-1:0]               m_status,
    output logic signed [deq_pkg::DATA_W-1:0]          m_front_value,
    output logic signed [deq_pkg::DATA_W-1:0]          m_back_value,
    output logic [deq_pkg::COUNT_W-1:0]                m_count,
    output logic                                       m_is_empty
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     rev_reg, rev_next;
    logic                     m_valid_reg;
    status_t                  status_reg, status_next;
    logic signed [DATA_W-1:0] front_reg, front_next;
    logic signed [DATA_W-1:0] back_reg, back_next;
    logic [COUNT_W-1:0]       m_count_reg;
    logic                     empty_reg;

    logic                     fire;
    logic                     full, empty;
    logic                     do_push, do_pop, at_start;
    cell_ctrl_t               ctrl_fwd, ctrl_bwd;
    logic signed [DATA_W-1:0] first_next, last_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    // map the logical end onto the physical one
    always_comb begin
        do_push  = 1'b0;
        do_pop   = 1'b0;
        at_start = 1'b0;
        unique case (s_action)
            ACT_PUSH_FRONT: begin do_push = 1'b1; at_start = !rev_reg; end
            ACT_PUSH_BACK:  begin do_push = 1'b1; at_start = rev_reg;  end
            ACT_POP_FRONT:  begin do_pop  = 1'b1; at_start = !rev_reg; end
            ACT_POP_BACK:   begin do_pop  = 1'b1; at_start = rev_reg;  end
            default: ;
        endcase
    end

    always_comb begin
        ctrl_fwd.op        = CELL_HOLD;
        ctrl_fwd.push_data = s_value;
        ctrl_bwd.op        = CELL_HOLD;
        ctrl_bwd.push_data = s_value;
        count_next         = count_reg;
        rev_next           = rev_reg;
        status_next        = ST_DONE;
        if (fire) begin
            if (do_push) begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    count_next  = count_reg + 1'b1;
                    ctrl_fwd.op = at_start ? CELL_SHIFT_IN : CELL_APPEND;
                    ctrl_bwd.op = at_start ? CELL_APPEND : CELL_SHIFT_IN;
                end
            end else if (do_pop) begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    count_next  = count_reg - 1'b1;
                    ctrl_fwd.op = at_start ? CELL_SHIFT_OUT : CELL_HOLD;
                    ctrl_bwd.op = at_start ? CELL_HOLD : CELL_SHIFT_OUT;
                end
            end else if (s_action == ACT_CLEAR) begin
                count_next = '0;
            end else if (s_action == ACT_REVERSE) begin
                rev_next = !rev_reg;
            end
        end
    end

    deq_row #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_row_fwd (
        .aclk      (aclk),
        .ctrl      (ctrl_fwd),
        .count     (count_reg),
        .head_next (first_next)
    );

    deq_row #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_row_bwd (
        .aclk      (aclk),
        .ctrl      (ctrl_bwd),
        .count     (count_reg),
        .head_next (last_next)
    );

    always_comb begin
        if (count_next == '0) begin
            front_next = '1;
            back_next  = '1;
        end else if (rev_next) begin
            front_next = last_next;
            back_next  = first_next;
        end else begin
            front_next = first_next;
            back_next  = last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            rev_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            rev_reg   <= rev_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result beat payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            status_reg  <= status_next;
            front_reg   <= front_next;
            back_reg    <= back_next;
            m_count_reg <= COUNT_W'({{COUNT_W{1'b0}}, count_next});
            empty_reg   <= (count_next == '0);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_front_value = front_reg;
    assign m_back_value  = back_reg;
    assign m_count       = m_count_reg;
    assign m_is_empty    = empty_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(DEPTH))
        else $error("element count beyond depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && do_push && !full |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted push did not grow the count");

    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && do_pop && empty |=> m_status == ST_EMPTY && m_is_empty)
        else $error("pop on empty queue not flagged");

    a_reverse_flips: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && s_action == ACT_REVERSE |=> rev_reg != $past(rev_reg))
        else $error("reverse did not toggle direction");

    a_empty_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(fire) && count_reg == '0 |-> m_front_value == '1 && m_back_value == '1)
        else $error("empty queue reports stored values");
`endif

endmodule

`default_nettype wire

/* design/deq_cell.sv */
// ----------------------------------------------------------------------------
// deq_cell: one storage cell of a queue row
// Holds one value; loads from its left or right neighbour when the row
// shifts, or takes the pushed value when it is the first free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  wire logic                                aclk,
    input  wire deq_pkg::cell_ctrl_t                 ctrl,
    input  wire logic [CNT_W-1:0]                    count,
    input  wire logic signed [deq_pkg::DATA_W-1:0]   left_data,
    input  wire logic signed [deq_pkg::DATA_W-1:0]   right_data,
    output logic signed [deq_pkg::DATA_W-1:0]        data
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     tail_hit;

    assign tail_hit = (count == CNT_W'(INDEX));

    always_comb begin
        unique case (ctrl.op)
            CELL_HOLD:      data_next = data_reg;
            CELL_SHIFT_IN:  data_next = left_data;
            CELL_SHIFT_OUT: data_next = right_data;
            CELL_APPEND:    data_next = tail_hit ? ctrl.push_data : data_reg;
            default:        data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* design/deq_row.sv */
// ----------------------------------------------------------------------------
// deq_row: a row of DEPTH storage cells
// Element i of the row sits in cell i; the row shifts as a whole at its
// head end and appends at the cell that the count points to.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_row #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                                aclk,
    input  wire deq_pkg::cell_ctrl_t                 ctrl,
    input  wire logic [CNT_W-1:0]                    count,
    output logic signed [deq_pkg::DATA_W-1:0]        head_next
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DATA_W-1:0] left_in;
        logic signed [DATA_W-1:0] right_in;

        if (i == 0) begin : g_first
            assign left_in = ctrl.push_data;
        end else begin : g_mid_left
            assign left_in = cell_data[i-1];
        end

        // last cell never shifts out anything meaningful
        if (i == DEPTH - 1) begin : g_last
            assign right_in = cell_data[i];
        end else begin : g_mid_right
            assign right_in = cell_data[i+1];
        end

        deq_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .count      (count),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i])
        );
    end

    // value that cell 0 will hold after this cycle
    always_comb begin
        unique case (ctrl.op)
            CELL_HOLD:      head_next = cell_data[0];
            CELL_SHIFT_IN:  head_next = ctrl.push_data;
            CELL_SHIFT_OUT: head_next = cell_data[1];
            CELL_APPEND:    head_next = (count == '0) ? ctrl.push_data : cell_data[0];
            default:        head_next = cell_data[0];
        endcase
    end

endmodule

`default_nettype wire
